// File: design/dq_pkg.sv
// Package for the double-ended queue: operation codes and the control
// bundle handed to every storage cell. No dependencies.
`default_nettype none

package dq_pkg;

  // Operation requested by one input item
  typedef enum logic [1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_POP_BACK   = 2'd1,
    FUNC_PUSH_FRONT = 2'd2,
    FUNC_POP_FRONT  = 2'd3
  } dq_func_e;

  // Per-cycle command broadcast to the cell row; at most one bit is set
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic pop_back;
  } dq_cell_ctl_t;

endpackage

`default_nettype wire

// File: design/dq_if.sv
// Request and response channel interfaces of the double-ended queue.
// Depends on dq_pkg for the operation code type.
`default_nettype none

interface dq_req_if #(
  parameter int DATA_WIDTH = 32
);
  import dq_pkg::*;

  logic                  valid;
  logic                  ready;
  dq_func_e              func;
  logic [DATA_WIDTH-1:0] data_in;

  modport source (output valid, output func, output data_in, input ready);
  modport sink   (input valid, input func, input data_in, output ready);
endinterface

interface dq_rsp_if #(
  parameter int DATA_WIDTH = 32,
  parameter int SLOT_W     = 4,
  parameter int COUNT_W    = 5
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data_out;
  logic [SLOT_W-1:0]     slot;
  logic                  full_error;
  logic                  empty_error;
  logic [COUNT_W-1:0]    count;

  modport source (output valid, output data_out, output slot, output full_error,
                  output empty_error, output count, input ready);
  modport sink   (input valid, input data_out, input slot, input full_error,
                  input empty_error, input count, output ready);
endinterface

`default_nettype wire

// File: design/dq_cell.sv
// One storage cell of the queue row: holds one element and its valid bit,
// shifting with its neighbors on front operations. Depends on dq_pkg.
`default_nettype none

module dq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire dq_pkg::dq_cell_ctl_t ctl_i,
  input  wire [DATA_WIDTH-1:0]  push_data_i,
  input  wire                   left_valid_i,
  input  wire [DATA_WIDTH-1:0]  left_data_i,
  input  wire                   right_valid_i,
  input  wire [DATA_WIDTH-1:0]  right_data_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] tail_data_o
);
  import dq_pkg::*;

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  is_tail;
  logic                  is_gap;

  // Last occupied cell, and first free cell behind the occupied run
  assign is_tail = valid_q & ~right_valid_i;
  assign is_gap  = ~valid_q & left_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    priority if (ctl_i.push_front) begin
      valid_d = left_valid_i;
      data_d  = left_data_i;
    end else if (ctl_i.pop_front) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end else if (ctl_i.push_back && is_gap) begin
      valid_d = 1'b1;
      data_d  = push_data_i;
    end else if (ctl_i.pop_back && is_tail) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o     = valid_q;
  assign data_o      = data_q;
  assign tail_data_o = is_tail ? data_q : '0;

endmodule

`default_nettype wire

// File: design/double_ended_queue_top.sv
// Top level of the double-ended queue: a row of dq_cell storage cells,
// circular slot indices, occupancy count and a registered response.
// Depends on dq_pkg, dq_if and dq_cell.
//
//   channel  | modport         | payload
//   ---------+-----------------+----------------------------------------------
//   req_i    | dq_req_if.sink  | func, data_in
//   rsp_o    | dq_rsp_if.source| data_out, slot, full_error, empty_error, count
//
// One request per cycle; its response appears in the result register on the
// next cycle. A request is taken whenever that register is empty or being
// drained in the same cycle, so a stalled response holds off new requests.
// Reset clears the indices, the count and every cell's valid bit at once;
// no clearing pass is needed. Elements live in the cell row, front at cell 0.
`default_nettype none

module double_ended_queue_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);
  import dq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic [IDX_W-1:0] front_q, front_d;
  logic [IDX_W-1:0] back_q, back_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic                  rsp_valid_q;
  logic [DATA_WIDTH-1:0] rsp_data_q, rsp_data_d;
  logic [IDX_W-1:0]      rsp_slot_q, rsp_slot_d;
  logic                  rsp_full_q, rsp_full_d;
  logic                  rsp_empty_q, rsp_empty_d;

  logic accept;
  logic is_full;
  logic is_empty;
  dq_cell_ctl_t cell_ctl;

  logic [CAPACITY-1:0]   cell_valid;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] tail_data [CAPACITY];
  logic [DATA_WIDTH-1:0] back_data;

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? LAST_IDX : idx - 1'b1;
  endfunction

  assign req_i.ready = ~rsp_valid_q | rsp_o.ready;
  assign accept      = req_i.valid & req_i.ready;
  assign is_full     = (count_q == FULL_CNT);
  assign is_empty    = (count_q == '0);

  // Broadcast the command to the cell row only when it succeeds
  always_comb begin
    cell_ctl            = '0;
    cell_ctl.push_back  = accept & (req_i.func == FUNC_PUSH_BACK)  & ~is_full;
    cell_ctl.pop_back   = accept & (req_i.func == FUNC_POP_BACK)   & ~is_empty;
    cell_ctl.push_front = accept & (req_i.func == FUNC_PUSH_FRONT) & ~is_full;
    cell_ctl.pop_front  = accept & (req_i.func == FUNC_POP_FRONT)  & ~is_empty;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  left_valid;
    logic [DATA_WIDTH-1:0] left_data;
    logic                  right_valid;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_data  = req_i.data_in;
    end else begin : g_mid
      assign left_valid = cell_valid[i-1];
      assign left_data  = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_valid = 1'b0;
      assign right_data  = '0;
    end else begin : g_next
      assign right_valid = cell_valid[i+1];
      assign right_data  = cell_data[i+1];
    end

    dq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl),
      .push_data_i  (req_i.data_in),
      .left_valid_i (left_valid),
      .left_data_i  (left_data),
      .right_valid_i(right_valid),
      .right_data_i (right_data),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i]),
      .tail_data_o  (tail_data[i])
    );
  end

  // Only the tail cell drives nonzero data, so an OR picks it out
  always_comb begin
    back_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_data = back_data | tail_data[i];
    end
  end

  always_comb begin
    front_d     = front_q;
    back_d      = back_q;
    count_d     = count_q;
    rsp_data_d  = '0;
    rsp_slot_d  = '0;
    rsp_full_d  = 1'b0;
    rsp_empty_d = 1'b0;
    unique case (req_i.func)
      FUNC_PUSH_BACK: begin
        if (is_full) begin
          rsp_full_d = 1'b1;
        end else begin
          rsp_slot_d = back_q;
          back_d     = step_up(back_q);
          count_d    = count_q + 1'b1;
        end
      end
      FUNC_POP_BACK: begin
        if (is_empty) begin
          rsp_empty_d = 1'b1;
        end else begin
          back_d     = step_down(back_q);
          rsp_slot_d = back_d;
          rsp_data_d = back_data;
          count_d    = count_q - 1'b1;
        end
      end
      FUNC_PUSH_FRONT: begin
        if (is_full) begin
          rsp_full_d = 1'b1;
        end else begin
          front_d    = step_down(front_q);
          rsp_slot_d = front_d;
          count_d    = count_q + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (is_empty) begin
          rsp_empty_d = 1'b1;
        end else begin
          rsp_slot_d = front_q;
          front_d    = step_up(front_q);
          rsp_data_d = cell_data[0];
          count_d    = count_q - 1'b1;
        end
      end
      default: begin
        rsp_full_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        front_q     <= front_d;
        back_q      <= back_d;
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_data_q  <= rsp_data_d;
      rsp_slot_q  <= rsp_slot_d;
      rsp_full_q  <= rsp_full_d;
      rsp_empty_q <= rsp_empty_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.data_out    = rsp_data_q;
  assign rsp_o.slot        = rsp_slot_q;
  assign rsp_o.full_error  = rsp_full_q;
  assign rsp_o.empty_error = rsp_empty_q;
  assign rsp_o.count       = count_q;

  // Occupancy never exceeds the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("queue count above capacity");

  // Cell valid bits agree with the count
  a_cells_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(count_q))
    else $error("cell valid bits disagree with count");

  // Occupied cells form one run starting at cell 0
  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("cell row has a hole");

  // A refused pop leaves the queue empty
  a_empty_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rsp_empty_d |=> count_q == '0)
    else $error("empty error with elements held");

endmodule

`default_nettype wire
